### hw/rtl/chmd_pkg.sv
// shared types and codes for the chained hash map
package chmd_pkg;

    typedef enum logic [2:0] {
        OP_LOOKUP = 3'd0,
        OP_INSERT = 3'd1,
        OP_UPDATE = 3'd2,
        OP_REMOVE = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_PRESENT   = 3'd2,
        ST_FULL      = 3'd3,
        ST_RANGE     = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_SEARCH,
        S_ITEM,
        S_LAST,
        S_CHAIN_LAST,
        S_WRITE,
        S_READ_KEY,
        S_DONE
    } state_t;

    localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;

endpackage

### hw/rtl/chained_hash_map_dense_items.sv
// chained hash map with dense item store, top level
// steps from accept to result: hash the key, compare chain entries until a match or the chain
//   ends, read the item, then fetch the chain key for a read, write the item for an insert or
//   move the last item and last chain entry into the holes for a remove, and post the result
// one transaction at a time, taken only after the previous result is accepted
// reset clears the count, then a clearing pass zeroes the chain lengths of all SLOT_COUNT slots
module chained_hash_map_dense_items #(
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32,
    parameter int SLOT_COUNT  = 64,
    parameter int CHAIN_DEPTH = 4,
    parameter int CAPACITY    = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [31:0] key,
    input  logic [31:0] value,
    input  logic [7:0]  position,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] value_out,
    output logic [31:0] key_out,
    output logic [7:0]  item_position,
    output logic [8:0]  item_count
);
    localparam int SB  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int EB  = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
    localparam int IB  = $clog2(CAPACITY);
    localparam int CB  = $clog2(CAPACITY + 1);
    localparam int LB  = $clog2(CHAIN_DEPTH + 1);
    localparam int ENT = SLOT_COUNT * CHAIN_DEPTH;
    localparam int AB  = $clog2(ENT);
    localparam int CHW = KEY_WIDTH + IB;
    localparam int ITW = VALUE_WIDTH + SB + EB;

    // control registers
    chmd_pkg::state_t state_reg, state_next;
    logic [CB-1:0]    count_reg, count_next;
    logic [SB-1:0]    clr_reg, clr_next;   // clearing pass address
    logic             out_valid_reg, out_valid_next;

    // chain lengths: small memory, read at the hashed slot
    logic [LB-1:0]    clen_mem [SLOT_COUNT];
    logic [LB-1:0]    clen_rdata;

    // transaction registers
    chmd_pkg::op_t    op_reg, op_next;
    logic [KEY_WIDTH-1:0]   key_reg, key_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [7:0]       pos_reg, pos_next;
    logic [SB-1:0]    slot_reg, slot_next;
    logic [LB-1:0]    len_reg, len_next;
    logic [LB-1:0]    e_reg, e_next;       // entry under search
    logic             found_reg, found_next;
    logic [EB-1:0]    fe_reg, fe_next;     // entry found
    logic [IB-1:0]    item_reg, item_next;
    logic [2:0]       step_reg, step_next; // sub-step in multi-cycle states
    logic [ITW-1:0]   last_it_reg, last_it_next;
    logic [CHW-1:0]   last_ch_reg, last_ch_next;

    // result registers
    logic [2:0]  st_reg, st_next;
    logic [31:0] vo_reg, vo_next;
    logic [31:0] ko_reg, ko_next;
    logic [7:0]  ip_reg, ip_next;

    // hash unit, loaded with the key of the transaction being accepted
    logic          h_start, h_done;
    logic [SB-1:0] h_slot;

    chmd_hash #(.KEY_WIDTH(KEY_WIDTH), .SLOT_BITS(SB)) u_hash (
        .clk(clk), .rst_n(rst_n), .start(h_start), .key(key_next),
        .done(h_done), .slot(h_slot)
    );

    // chain ram: {key, item ref}
    logic           c_we;
    logic [AB-1:0]  c_addr;
    logic [CHW-1:0] c_wdata, c_rdata;
    chmd_ram #(.WIDTH(CHW), .DEPTH(ENT)) u_chain (
        .clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(c_rdata)
    );

    // item ram: {value, slot ref, entry ref}
    logic           i_we;
    logic [IB-1:0]  i_addr;
    logic [ITW-1:0] i_wdata, i_rdata;
    chmd_ram #(.WIDTH(ITW), .DEPTH(CAPACITY)) u_item (
        .clk(clk), .we(i_we), .addr(i_addr), .wdata(i_wdata), .rdata(i_rdata)
    );

    function automatic logic [AB-1:0] caddr(input logic [SB-1:0] s, input logic [EB-1:0] e);
        logic [AB+EB-1:0] t;
        t = (AB+EB)'(s) * (AB+EB)'(CHAIN_DEPTH) + (AB+EB)'(e);
        return t[AB-1:0];
    endfunction

    // chain length write strobe
    logic          clen_we;
    logic [SB-1:0] clen_waddr;
    logic [LB-1:0] clen_wdata;

    logic [KEY_WIDTH-1:0]   r_key;
    logic [IB-1:0]          r_ref;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [SB-1:0]          r_sref;
    logic [EB-1:0]          r_eref;
    logic [IB-1:0]          last_idx;
    logic [EB-1:0]          le_e;

    assign r_key  = c_rdata[CHW-1:IB];
    assign r_ref  = c_rdata[IB-1:0];
    assign r_val  = i_rdata[ITW-1:SB+EB];
    assign r_sref = i_rdata[SB+EB-1:EB];
    assign r_eref = i_rdata[EB-1:0];
    assign last_idx = IB'(count_reg - 1'b1);
    assign le_e     = EB'(len_reg - 1'b1);

    // result payload must hold while out_valid is up, so wait for it to be taken
    assign in_ready  = (state_reg == chmd_pkg::S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign status        = st_reg;
    assign value_out     = vo_reg;
    assign key_out       = ko_reg;
    assign item_position = ip_reg;
    assign item_count    = 9'(count_reg);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        clr_next   = clr_reg;
        out_valid_next = out_valid_reg;
        op_next = op_reg; key_next = key_reg; val_next = val_reg; pos_next = pos_reg;
        slot_next = slot_reg; len_next = len_reg; e_next = e_reg;
        found_next = found_reg; fe_next = fe_reg; item_next = item_reg;
        step_next = step_reg;
        last_it_next = last_it_reg; last_ch_next = last_ch_reg;
        st_next = st_reg; vo_next = vo_reg; ko_next = ko_reg; ip_next = ip_reg;
        h_start = 1'b0;
        c_we = 1'b0; c_addr = caddr(slot_reg, EB'(e_reg)); c_wdata = '0;
        i_we = 1'b0; i_addr = item_reg; i_wdata = '0;
        clen_we = 1'b0; clen_waddr = slot_reg; clen_wdata = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            chmd_pkg::S_CLEAR:
            begin
                // zero one chain length per cycle after reset
                clen_we    = 1'b1;
                clen_waddr = clr_reg;
                clen_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == SB'(SLOT_COUNT - 1))
                    state_next = chmd_pkg::S_IDLE;
            end
            chmd_pkg::S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    op_next  = chmd_pkg::op_t'(operation);
                    key_next = KEY_WIDTH'(key);
                    val_next = VALUE_WIDTH'(value);
                    pos_next = position;
                    h_start  = 1'b1;
                    state_next = chmd_pkg::S_HASH;
                end
            end
            chmd_pkg::S_HASH:
            begin
                // step 0 waits for the slot, step 1 takes the chain length read at it
                if (step_reg == 3'd0)
                begin
                    if (h_done)
                        step_next = 3'd1;
                end
                else
                begin
                    slot_next  = h_slot;
                    len_next   = clen_rdata;
                    e_next     = '0;
                    found_next = 1'b0;
                    step_next  = '0;
                    state_next = chmd_pkg::S_SEARCH;
                end
            end
            chmd_pkg::S_SEARCH:
            begin
                // step 0 issues read of entry e, step 1 compares
                if (step_reg == 3'd0)
                begin
                    if (e_reg >= len_reg)
                    begin
                        step_next  = '0;
                        state_next = chmd_pkg::S_ITEM;
                    end
                    else
                    begin
                        c_addr    = caddr(slot_reg, EB'(e_reg));
                        step_next = 3'd1;
                    end
                end
                else
                begin
                    step_next = '0;
                    if (r_key == key_reg)
                    begin
                        found_next = 1'b1;
                        fe_next    = EB'(e_reg);
                        item_next  = r_ref;
                        state_next = chmd_pkg::S_ITEM;
                    end
                    else
                        e_next = e_reg + 1'b1;
                end
            end
            chmd_pkg::S_ITEM:
            begin
                // read the found item (or read position), then decide
                if (step_reg == 3'd0)
                begin
                    i_addr    = (op_reg == chmd_pkg::OP_READ) ? IB'(pos_reg) : item_reg;
                    step_next = 3'd1;
                end
                else
                begin
                    step_next = '0;
                    ko_next = 32'(key_reg);
                    vo_next = '0;
                    ip_next = '0;
                    st_next = chmd_pkg::ST_OK;
                    state_next = chmd_pkg::S_DONE;
                    unique case (op_reg)
                        chmd_pkg::OP_INSERT:
                        begin
                            if (found_reg)
                            begin
                                st_next = chmd_pkg::ST_PRESENT;
                                ip_next = 8'(item_reg);
                            end
                            else if (count_reg >= CB'(CAPACITY)
                                     || len_reg >= LB'(CHAIN_DEPTH))
                                st_next = chmd_pkg::ST_FULL;
                            else
                            begin
                                c_we    = 1'b1;
                                c_addr  = caddr(slot_reg, EB'(len_reg));
                                c_wdata = {key_reg, IB'(count_reg)};
                                ip_next = 8'(count_reg);
                                state_next = chmd_pkg::S_WRITE;
                            end
                        end
                        chmd_pkg::OP_UPDATE:
                        begin
                            if (!found_reg)
                                st_next = chmd_pkg::ST_NOT_FOUND;
                            else
                            begin
                                i_we    = 1'b1;
                                i_addr  = item_reg;
                                i_wdata = {val_reg, r_sref, r_eref};
                                vo_next = 32'(val_reg);
                                ip_next = 8'(item_reg);
                            end
                        end
                        chmd_pkg::OP_REMOVE:
                        begin
                            if (!found_reg || count_reg == '0)
                                st_next = chmd_pkg::ST_NOT_FOUND;
                            else
                            begin
                                vo_next = 32'(r_val);
                                ip_next = 8'(item_reg);
                                state_next = chmd_pkg::S_LAST;
                            end
                        end
                        chmd_pkg::OP_READ:
                        begin
                            if (CB'(pos_reg) >= count_reg || 32'(pos_reg) >= CAPACITY)
                                st_next = chmd_pkg::ST_RANGE;
                            else
                            begin
                                vo_next = 32'(r_val);
                                ip_next = pos_reg;
                                state_next = chmd_pkg::S_READ_KEY;
                            end
                        end
                        default:
                        begin
                            if (!found_reg)
                                st_next = chmd_pkg::ST_NOT_FOUND;
                            else
                            begin
                                vo_next = 32'(r_val);
                                ip_next = 8'(item_reg);
                            end
                        end
                    endcase
                end
            end
            chmd_pkg::S_READ_KEY:
            begin
                // item ram holds the read item; fetch its chain key
                if (step_reg == 3'd0)
                begin
                    i_addr    = IB'(pos_reg);
                    step_next = 3'd1;
                end
                else if (step_reg == 3'd1)
                begin
                    c_addr    = caddr(r_sref, r_eref);
                    step_next = 3'd2;
                end
                else
                begin
                    ko_next    = 32'(r_key);
                    step_next  = '0;
                    state_next = chmd_pkg::S_DONE;
                end
            end
            chmd_pkg::S_WRITE:
            begin
                // insert: item entry, chain length, count
                i_we    = 1'b1;
                i_addr  = IB'(count_reg);
                i_wdata = {val_reg, slot_reg, EB'(len_reg)};
                clen_we = 1'b1;
                clen_wdata = len_reg + 1'b1;
                count_next = count_reg + 1'b1;
                state_next = chmd_pkg::S_DONE;
            end
            chmd_pkg::S_LAST:
            begin
                // move last item into the hole and repoint its chain entry
                if (step_reg == 3'd0)
                begin
                    i_addr    = last_idx;
                    step_next = 3'd1;
                end
                else if (step_reg == 3'd1)
                begin
                    last_it_next = i_rdata;
                    c_addr       = caddr(r_sref, r_eref);
                    step_next    = 3'd2;
                end
                else
                begin
                    if (item_reg < last_idx)
                    begin
                        i_we    = 1'b1;
                        i_addr  = item_reg;
                        i_wdata = last_it_reg;
                        c_we    = 1'b1;
                        c_addr  = caddr(last_it_reg[SB+EB-1:EB], last_it_reg[EB-1:0]);
                        c_wdata = {r_key, item_reg};
                    end
                    count_next = count_reg - 1'b1;
                    step_next  = '0;
                    state_next = chmd_pkg::S_CHAIN_LAST;
                end
            end
            chmd_pkg::S_CHAIN_LAST:
            begin
                // move last chain entry into the chain hole and fix its item
                if (step_reg == 3'd0)
                begin
                    c_addr    = caddr(slot_reg, le_e);
                    step_next = 3'd1;
                end
                else if (step_reg == 3'd1)
                begin
                    last_ch_next = c_rdata;
                    i_addr       = r_ref;
                    step_next    = 3'd2;
                end
                else
                begin
                    if (fe_reg < le_e)
                    begin
                        c_we    = 1'b1;
                        c_addr  = caddr(slot_reg, fe_reg);
                        c_wdata = last_ch_reg;
                        i_we    = 1'b1;
                        i_addr  = last_ch_reg[IB-1:0];
                        i_wdata = {r_val, r_sref, fe_reg};
                    end
                    clen_we    = 1'b1;
                    clen_wdata = len_reg - 1'b1;
                    step_next  = '0;
                    state_next = chmd_pkg::S_DONE;
                end
            end
            chmd_pkg::S_DONE:
            begin
                // wait for the result register to be free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = chmd_pkg::S_IDLE;
                end
            end
            default: state_next = chmd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= chmd_pkg::S_CLEAR;
            count_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    // chain length memory, read at the slot coming out of the hash unit
    always_ff @(posedge clk)
    begin
        if (clen_we)
            clen_mem[clen_waddr] <= clen_wdata;
        clen_rdata <= clen_mem[h_slot];
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next; key_reg <= key_next; val_reg <= val_next; pos_reg <= pos_next;
        slot_reg <= slot_next; len_reg <= len_next; e_reg <= e_next;
        found_reg <= found_next; fe_reg <= fe_next; item_reg <= item_next;
        last_it_reg <= last_it_next; last_ch_reg <= last_ch_next;
        st_reg <= st_next; vo_reg <= vo_next; ko_reg <= ko_next; ip_reg <= ip_next;
    end
endmodule

### hw/rtl/chmd_hash.sv
// fnv-1a slot hash, one key byte per cycle
module chmd_hash #(
    parameter int KEY_WIDTH  = 32,
    parameter int SLOT_BITS  = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [KEY_WIDTH-1:0] key,
    output logic                 done,
    output logic [SLOT_BITS-1:0] slot
);
    localparam int NBYTES = (KEY_WIDTH + 7) / 8;
    localparam int CW = $clog2(NBYTES + 1);

    logic [31:0]          h_reg, h_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [NBYTES*8-1:0]  key_reg, key_next;
    logic [31:0]          mix;

    assign mix  = h_reg ^ {24'd0, key_reg[7:0]};
    assign done = busy_reg && (cnt_reg == CW'(NBYTES));
    assign slot = h_reg[SLOT_BITS-1:0];

    always_comb
    begin
        h_next    = h_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        key_next  = key_reg;
        if (start)
        begin
            h_next    = chmd_pkg::FNV_OFFSET;
            cnt_next  = '0;
            busy_next = 1'b1;
            key_next  = (NBYTES*8)'(key);
        end
        else if (busy_reg && cnt_reg != CW'(NBYTES))
        begin
            h_next   = mix * chmd_pkg::FNV_PRIME;
            cnt_next = cnt_reg + 1'b1;
            key_next = key_reg >> 8;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg   <= h_next;
        key_reg <= key_next;
    end
endmodule

### hw/rtl/chmd_ram.sv
// single-port synchronous memory, registered read
module chmd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
